@@ design/cbfr_pkg.sv @@
// Shared types, widths and codes for the clocked bus frame receiver and writer.
package cbfr_pkg;

    localparam int MSG_BYTES   = 32;
    localparam int WRITE_SLOTS = 4;

    localparam int BP_W    = $clog2(MSG_BYTES);
    localparam int LEN_W   = 6;
    localparam int QIDX_W  = (WRITE_SLOTS > 1) ? $clog2(WRITE_SLOTS) : 1;
    localparam int QCNT_W  = $clog2(WRITE_SLOTS + 1);
    localparam int BC_W    = 9;
    localparam int GAP_W   = 16;
    localparam int STALL_W = 20;
    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 20;
    localparam int CIDX_W  = 2;

    localparam logic [GAP_W-1:0]   GAP_RESET   = 16'd2000;
    localparam logic [STALL_W-1:0] STALL_RESET = 20'd500000;
    localparam logic [BYTE_W-1:0]  TRIG_RESET  = 8'h05;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_GAP   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_STALL = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_TRIG  = 2'd2;

    // item opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_EDGE  = 2'd1;
    localparam logic [1:0] OP_QUEUE = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // result kinds
    localparam logic KIND_DRIVE = 1'b0;
    localparam logic KIND_MSG   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DISP_RD,
        ST_DISP_EMIT,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic load_item;
        logic rd_byte;
        logic emit_byte;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic disp_need;
        logic item_nop;
        logic last_byte;
        logic out_free;
    } status_t;

endpackage

@@ design/cbfr_ctrl.sv @@
// Controller: sequences item intake, message dispatch and item execution.
module cbfr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  cbfr_pkg::status_t status,
    output cbfr_pkg::cmd_t    cmd,
    output logic              in_stall
);

    cbfr_pkg::state_t state_reg;
    cbfr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cbfr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cbfr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.disp_need)
                    begin
                        state_next = cbfr_pkg::ST_DISP_RD;
                    end
                    else if (!status.item_nop)
                    begin
                        state_next = cbfr_pkg::ST_EXEC;
                    end
                end
            end
            cbfr_pkg::ST_DISP_RD:
            begin
                state_next = cbfr_pkg::ST_DISP_EMIT;
            end
            cbfr_pkg::ST_DISP_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.last_byte ? cbfr_pkg::ST_EXEC : cbfr_pkg::ST_DISP_RD;
                end
            end
            cbfr_pkg::ST_EXEC:
            begin
                if (status.out_free)
                begin
                    state_next = cbfr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cbfr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall      = (state_reg != cbfr_pkg::ST_IDLE);
        cmd.load_item = (state_reg == cbfr_pkg::ST_IDLE) && in_valid;
        cmd.rd_byte   = (state_reg == cbfr_pkg::ST_DISP_RD);
        cmd.emit_byte = (state_reg == cbfr_pkg::ST_DISP_EMIT) && status.out_free;
        cmd.exec      = (state_reg == cbfr_pkg::ST_EXEC) && status.out_free;
    end

endmodule

@@ design/cbfr_dp.sv @@
// Datapath: bus state, message buffer, write queue, config and output register.
module cbfr_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [cbfr_pkg::CIDX_W-1:0]        cfg_index,
    input  logic [cbfr_pkg::CFG_W-1:0]         cfg_data,
    input  logic [1:0]                         opcode,
    input  logic                               clock_level,
    input  logic                               data_level,
    input  logic [cbfr_pkg::BYTE_W-1:0]        write_value,
    input  logic                               out_stall,
    input  cbfr_pkg::cmd_t                     cmd,
    output cbfr_pkg::status_t                  status,
    output logic                               out_valid,
    output logic                               kind,
    output logic                               drive_enable,
    output logic                               drive_level,
    output logic [cbfr_pkg::BYTE_W-1:0]        msg_byte,
    output logic [cbfr_pkg::LEN_W-1:0]         msg_length,
    output logic                               last,
    output logic                               write_dropped
);

    localparam logic [cbfr_pkg::BC_W-1:0]    BC_MAX    = '1;
    localparam logic [cbfr_pkg::GAP_W-1:0]   GAP_MAX   = '1;
    localparam logic [cbfr_pkg::STALL_W-1:0] STALL_MAX = '1;
    localparam logic [cbfr_pkg::BP_W-1:0]    BP_TOP    = cbfr_pkg::BP_W'(cbfr_pkg::MSG_BYTES - 1);
    localparam logic [cbfr_pkg::BP_W-1:0]    BP_WRITE  = cbfr_pkg::BP_W'(2);
    localparam logic [cbfr_pkg::QIDX_W-1:0]  QIDX_TOP  =
        cbfr_pkg::QIDX_W'(cbfr_pkg::WRITE_SLOTS - 1);
    localparam logic [cbfr_pkg::QCNT_W-1:0]  QCNT_FULL = cbfr_pkg::QCNT_W'(cbfr_pkg::WRITE_SLOTS);
    localparam logic [cbfr_pkg::QCNT_W:0]    QSUM_WRAP = (cbfr_pkg::QCNT_W+1)'(cbfr_pkg::WRITE_SLOTS);

    // configuration
    logic [cbfr_pkg::GAP_W-1:0]   gap_ticks_reg;
    logic [cbfr_pkg::STALL_W-1:0] stall_ticks_reg;
    logic [cbfr_pkg::BYTE_W-1:0]  trig_reg;

    // latched item
    logic [1:0]                  op_reg;
    logic                        clk_lvl_reg;
    logic                        dat_reg;
    logic [cbfr_pkg::BYTE_W-1:0] wv_reg;

    // bus state
    logic [cbfr_pkg::BP_W-1:0]    bp_reg, bp_next;
    logic [cbfr_pkg::BC_W-1:0]    bc_reg, bc_next;
    logic [cbfr_pkg::GAP_W-1:0]   gap_reg, gap_next;
    logic [cbfr_pkg::STALL_W-1:0] stall_reg, stall_next;
    logic [cbfr_pkg::BYTE_W-1:0]  cur_reg, cur_next;
    logic [cbfr_pkg::BYTE_W-1:0]  byte0_reg, byte0_next;
    logic                         writing_reg, writing_next;
    logic [cbfr_pkg::BYTE_W-1:0]  active_reg, active_next;
    logic                         en_reg, en_next;
    logic                         lv_reg, lv_next;
    logic [cbfr_pkg::QCNT_W-1:0]  qcount_reg, qcount_next;
    logic [cbfr_pkg::QIDX_W-1:0]  qhead_reg, qhead_next;

    // dispatch
    logic [cbfr_pkg::BP_W-1:0]    idx_reg;
    logic [cbfr_pkg::BYTE_W-1:0]  rd_data_reg;

    // output register
    logic                         out_valid_reg;
    logic                         kind_reg;
    logic                         en_out_reg;
    logic                         lv_out_reg;
    logic [cbfr_pkg::BYTE_W-1:0]  byte_out_reg;
    logic [cbfr_pkg::LEN_W-1:0]   len_out_reg;
    logic                         last_out_reg;
    logic                         drop_out_reg;

    logic [cbfr_pkg::BYTE_W-1:0]  msg_mem [cbfr_pkg::MSG_BYTES];
    logic [cbfr_pkg::BYTE_W-1:0]  q_store [cbfr_pkg::WRITE_SLOTS];

    // combinational execution values
    logic                         gap_hit;
    logic                         mem_we;
    logic                         q_we;
    logic [cbfr_pkg::QIDX_W-1:0]  q_slot;
    logic [cbfr_pkg::QCNT_W:0]    q_sum;
    logic                         drop;
    logic                         res_drive;
    logic [cbfr_pkg::BP_W-1:0]    bp0;
    logic [cbfr_pkg::BC_W-1:0]    bc0;
    logic [cbfr_pkg::BC_W-1:0]    bc1;
    logic [cbfr_pkg::BYTE_W-1:0]  cur0;
    logic [cbfr_pkg::BYTE_W-1:0]  cur1;
    logic                         boundary;
    logic                         start_wr;
    logic [cbfr_pkg::BYTE_W-1:0]  act_eff;
    logic [2:0]                   bit_idx;
    logic [cbfr_pkg::STALL_W-1:0] stall_inc;
    logic [cbfr_pkg::LEN_W-1:0]   msg_len;

    assign gap_hit = gap_reg > gap_ticks_reg;
    assign msg_len = cbfr_pkg::LEN_W'(bp_reg) + cbfr_pkg::LEN_W'(1);

    assign status.disp_need = (opcode == cbfr_pkg::OP_EDGE) && gap_hit && (bp_reg > BP_WRITE);
    assign status.item_nop  = (opcode == cbfr_pkg::OP_NONE);
    assign status.last_byte = (idx_reg == bp_reg);
    assign status.out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_ticks_reg   <= cbfr_pkg::GAP_RESET;
            stall_ticks_reg <= cbfr_pkg::STALL_RESET;
            trig_reg        <= cbfr_pkg::TRIG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cbfr_pkg::CFG_GAP:   gap_ticks_reg   <= cfg_data[cbfr_pkg::GAP_W-1:0];
                cbfr_pkg::CFG_STALL: stall_ticks_reg <= cfg_data[cbfr_pkg::STALL_W-1:0];
                cbfr_pkg::CFG_TRIG:  trig_reg        <= cfg_data[cbfr_pkg::BYTE_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg      <= opcode;
            clk_lvl_reg <= clock_level;
            dat_reg     <= data_level;
            wv_reg      <= write_value;
        end
    end

    always_comb
    begin
        bp_next      = bp_reg;
        bc_next      = bc_reg;
        gap_next     = gap_reg;
        stall_next   = stall_reg;
        cur_next     = cur_reg;
        byte0_next   = byte0_reg;
        writing_next = writing_reg;
        active_next  = active_reg;
        en_next      = en_reg;
        lv_next      = lv_reg;
        qcount_next  = qcount_reg;
        qhead_next   = qhead_reg;
        mem_we       = 1'b0;
        q_we         = 1'b0;
        drop         = 1'b0;

        bp0       = gap_hit ? '0 : bp_reg;
        bc0       = gap_hit ? '0 : bc_reg;
        cur0      = gap_hit ? '0 : cur_reg;
        bc1       = (bc0 < BC_MAX) ? bc0 + cbfr_pkg::BC_W'(1) : bc0;
        cur1      = {cur0[cbfr_pkg::BYTE_W-2:0], dat_reg};
        // boundaries after bit 8, bit 9, then every 8 bits
        boundary  = (bc1 == cbfr_pkg::BC_W'(8)) || (bc1 == cbfr_pkg::BC_W'(9)) ||
                    ((bc1 > cbfr_pkg::BC_W'(9)) && (bc1[2:0] == 3'd1));
        start_wr  = (bp0 == BP_WRITE) && (bc0 <= cbfr_pkg::BC_W'(9)) &&
                    (byte0_reg == trig_reg) && (qcount_reg != '0);
        act_eff   = start_wr ? q_store[qhead_reg] : active_reg;
        bit_idx   = 3'(5'd16 - bc0[4:0]);
        stall_inc = (stall_reg < STALL_MAX) ? stall_reg + cbfr_pkg::STALL_W'(1) : stall_reg;
        q_sum     = (cbfr_pkg::QCNT_W+1)'(qhead_reg) + (cbfr_pkg::QCNT_W+1)'(qcount_reg);
        q_slot    = (q_sum >= QSUM_WRAP) ? cbfr_pkg::QIDX_W'(q_sum - QSUM_WRAP)
                                         : cbfr_pkg::QIDX_W'(q_sum);

        if (cmd.exec)
        begin
            case (op_reg)
                cbfr_pkg::OP_TICK:
                begin
                    gap_next   = (gap_reg < GAP_MAX) ? gap_reg + cbfr_pkg::GAP_W'(1) : gap_reg;
                    stall_next = stall_inc;
                    if (stall_inc > stall_ticks_reg)
                    begin
                        en_next      = 1'b0;
                        lv_next      = 1'b0;
                        writing_next = 1'b0;
                    end
                end
                cbfr_pkg::OP_QUEUE:
                begin
                    if (qcount_reg < QCNT_FULL)
                    begin
                        q_we        = 1'b1;
                        qcount_next = qcount_reg + cbfr_pkg::QCNT_W'(1);
                    end
                    else
                    begin
                        drop = 1'b1;
                    end
                end
                cbfr_pkg::OP_EDGE:
                begin
                    if (gap_hit && (bp_reg > BP_WRITE))
                    begin
                        stall_next = '0;
                    end
                    bp_next  = bp0;
                    bc_next  = bc0;
                    cur_next = cur0;
                    if (clk_lvl_reg)
                    begin
                        en_next = 1'b0;
                        lv_next = 1'b0;
                        bc_next = bc1;
                        if (boundary && (bp0 < BP_TOP))
                        begin
                            mem_we   = 1'b1;
                            bp_next  = bp0 + cbfr_pkg::BP_W'(1);
                            cur_next = '0;
                            if (bp0 == '0)
                            begin
                                byte0_next = cur1;
                            end
                        end
                        else
                        begin
                            cur_next = cur1;
                        end
                    end
                    else
                    begin
                        if (start_wr)
                        begin
                            active_next  = act_eff;
                            qhead_next   = (qhead_reg == QIDX_TOP) ? '0
                                                                   : qhead_reg + cbfr_pkg::QIDX_W'(1);
                            qcount_next  = qcount_reg - cbfr_pkg::QCNT_W'(1);
                            writing_next = 1'b1;
                        end
                        if (start_wr || writing_reg)
                        begin
                            if (bp0 > BP_WRITE)
                            begin
                                en_next      = 1'b0;
                                lv_next      = 1'b0;
                                writing_next = 1'b0;
                            end
                            else
                            begin
                                en_next = 1'b1;
                                lv_next = (bc0 >= cbfr_pkg::BC_W'(9)) &&
                                          (bc0 <= cbfr_pkg::BC_W'(16)) && act_eff[bit_idx];
                            end
                        end
                    end
                    gap_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        res_drive = cmd.exec && (drop || (en_next != en_reg) || (lv_next != lv_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bp_reg      <= '0;
            bc_reg      <= '0;
            gap_reg     <= GAP_MAX;
            stall_reg   <= '0;
            cur_reg     <= '0;
            byte0_reg   <= '0;
            writing_reg <= 1'b0;
            active_reg  <= '0;
            en_reg      <= 1'b0;
            lv_reg      <= 1'b0;
            qcount_reg  <= '0;
            qhead_reg   <= '0;
            idx_reg     <= '0;
        end
        else
        begin
            bp_reg      <= bp_next;
            bc_reg      <= bc_next;
            gap_reg     <= gap_next;
            stall_reg   <= stall_next;
            cur_reg     <= cur_next;
            byte0_reg   <= byte0_next;
            writing_reg <= writing_next;
            active_reg  <= active_next;
            en_reg      <= en_next;
            lv_reg      <= lv_next;
            qcount_reg  <= qcount_next;
            qhead_reg   <= qhead_next;
            if (cmd.load_item)
            begin
                idx_reg <= '0;
            end
            else if (cmd.emit_byte)
            begin
                idx_reg <= idx_reg + cbfr_pkg::BP_W'(1);
            end
        end
    end

    // message buffer: completed bytes below the current position
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            msg_mem[bp0] <= cur1;
        end
        if (cmd.rd_byte)
        begin
            rd_data_reg <= msg_mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_store[q_slot] <= wv_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_byte || res_drive)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_byte)
        begin
            kind_reg     <= cbfr_pkg::KIND_MSG;
            en_out_reg   <= 1'b0;
            lv_out_reg   <= 1'b0;
            // the byte in progress is held outside the buffer
            byte_out_reg <= status.last_byte ? cur_reg : rd_data_reg;
            len_out_reg  <= msg_len;
            last_out_reg <= status.last_byte;
            drop_out_reg <= 1'b0;
        end
        else if (res_drive)
        begin
            kind_reg     <= cbfr_pkg::KIND_DRIVE;
            en_out_reg   <= en_next;
            lv_out_reg   <= lv_next;
            byte_out_reg <= '0;
            len_out_reg  <= '0;
            last_out_reg <= 1'b0;
            drop_out_reg <= drop;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign drive_enable  = en_out_reg;
    assign drive_level   = lv_out_reg;
    assign msg_byte      = byte_out_reg;
    assign msg_length    = len_out_reg;
    assign last          = last_out_reg;
    assign write_dropped = drop_out_reg;

endmodule

@@ design/clocked_bus_frame_receiver_writer.sv @@
// Top level of the clocked bus frame receiver and writer.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  config  | in        | cfg_we             | cfg_index, cfg_data
//  items   | in        | in_valid, in_stall | opcode, clock_level, data_level, write_value
//  results | out       | out_valid,out_stall| kind, drive_enable, drive_level, msg_byte,
//          |           |                    | msg_length, last, write_dropped
//
// A tick, queue or plain edge item is first accepted, then executed.
// An edge that closes a message is accepted, then each of its bytes is read from the
// single registered read port of the message buffer and emitted, then the edge executes.
// Each result waits while out_stall holds the output register full.
// Reset is asynchronous; the message buffer needs no clearing pass.
module clocked_bus_frame_receiver_writer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [cbfr_pkg::CIDX_W-1:0] cfg_index,
    input  logic [cbfr_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  opcode,
    input  logic                        clock_level,
    input  logic                        data_level,
    input  logic [cbfr_pkg::BYTE_W-1:0] write_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        kind,
    output logic                        drive_enable,
    output logic                        drive_level,
    output logic [cbfr_pkg::BYTE_W-1:0] msg_byte,
    output logic [cbfr_pkg::LEN_W-1:0]  msg_length,
    output logic                        last,
    output logic                        write_dropped
);

    cbfr_pkg::cmd_t    cmd;
    cbfr_pkg::status_t status;

    cbfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    cbfr_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .opcode        (opcode),
        .clock_level   (clock_level),
        .data_level    (data_level),
        .write_value   (write_value),
        .out_stall     (out_stall),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .kind          (kind),
        .drive_enable  (drive_enable),
        .drive_level   (drive_level),
        .msg_byte      (msg_byte),
        .msg_length    (msg_length),
        .last          (last),
        .write_dropped (write_dropped)
    );

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> cmd.load_item)
        else $error("accepted item not loaded");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_item, cmd.rd_byte, cmd.emit_byte, cmd.exec}))
        else $error("more than one command at once");

    a_last_ends_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_byte && status.last_byte) |=> (!cmd.emit_byte && !cmd.rd_byte))
        else $error("dispatch continued past last byte");

    a_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_byte |=> (!cmd.rd_byte && in_stall))
        else $error("buffer read not followed by emit wait");

endmodule
